FILE: design/rscd_pkg.sv
// ---------------------------------------------------------------------------
// rscd_pkg: shared types and constants for the sprite column decoder
// Payload structs, controller/datapath interface structs, codes and widths.
// ---------------------------------------------------------------------------
package rscd_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int COORD_BITS_DEF   = 12;

    localparam int ZOOM_W      = 5;
    localparam int SRC_W       = 8;
    localparam int PROD_W      = SRC_W + ZOOM_W;
    localparam int CODE_W      = 9;
    localparam int OUT_COORD_W = 12;
    localparam int COLOR_W     = 32;
    localparam int RUN_W       = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(1);

    localparam logic [1:0] ACT_PALETTE = 2'd0;
    localparam logic [1:0] ACT_HEADER  = 2'd1;
    localparam logic [1:0] ACT_STREAM  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ZOOM   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = CFG_INDEX_W'(2);

    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [SRC_W-1:0]   palette_slot;
        logic [COLOR_W-1:0] palette_color;
        logic [SRC_W-1:0]   top_row;
        logic [SRC_W-1:0]   bottom_row;
        logic [SRC_W-1:0]   left_column;
        logic [SRC_W-1:0]   stream_byte;
    } item_t;

    typedef struct packed {
        logic                   kind;
        logic [OUT_COORD_W-1:0] pixel_x;
        logic [OUT_COORD_W-1:0] pixel_y;
        logic [CODE_W-1:0]      color_code;
        logic                   is_new_color;
        logic [CODE_W-1:0]      distinct_count;
    } result_t;

    typedef struct packed {
        logic capture;
        logic pal_start;
        logic pal_rd;
        logic pal_next;
        logic pal_found;
        logic pal_add;
        logic hdr_load;
        logic set_pending;
        logic lit_rd;
        logic lit_emit;
        logic run_load;
        logic run_dec;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       slot_ok;
        logic       idx_at_count;
        logic       match;
        logic       pending_nz;
        logic       literal_flag;
        logic       run_nz;
        logic       hit;
        logic       out_free;
    } dp_status_t;

endpackage

FILE: design/rle_sprite_column_decoder_core.sv
// ---------------------------------------------------------------------------
// rle_sprite_column_decoder_core: RLE sprite column decoder
// Palette dedup plus column-major run-length stream decode into pixel writes.
// ---------------------------------------------------------------------------
// One beat is worked on at a time and a held result does not block intake.
// A frame header goes through dispatch and a header load state; a control
// byte ends in dispatch. A literal byte goes through dispatch, a map read
// and an output state. A transparent run makes one position step per cycle
// in the run state. A palette entry does a read and a check for each of the
// distinct colors compared before the match or insert; the color memory
// has one registered read port. A result waiting on a stalled output holds
// the next emit back. Configuration writes are always ready.
module rle_sprite_column_decoder_core
#(
    parameter int PALETTE_SIZE = rscd_pkg::PALETTE_SIZE_DEF,
    parameter int COORD_BITS   = rscd_pkg::COORD_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  rscd_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output rscd_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rscd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rscd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rscd_pkg::ctrl_cmd_t  cmd;
    rscd_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    rscd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    rscd_dp
    #(
        .PALETTE_SIZE (PALETTE_SIZE),
        .COORD_BITS   (COORD_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: design/rscd_ctrl.sv
// ---------------------------------------------------------------------------
// rscd_ctrl: sequencing controller
// Dispatches each beat by action and steps the datapath through palette
// search, header load, literal writes and transparent runs.
// ---------------------------------------------------------------------------
module rscd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  rscd_pkg::dp_status_t  status,
    output rscd_pkg::ctrl_cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_P_START  = 4'd2;
    localparam logic [3:0] ST_P_READ   = 4'd3;
    localparam logic [3:0] ST_P_CMP    = 4'd4;
    localparam logic [3:0] ST_P_ADD    = 4'd5;
    localparam logic [3:0] ST_HDR      = 4'd6;
    localparam logic [3:0] ST_LIT_RD   = 4'd7;
    localparam logic [3:0] ST_LIT_OUT  = 4'd8;
    localparam logic [3:0] ST_RUN      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.action)
                    rscd_pkg::ACT_PALETTE: state_next = ST_P_START;
                    rscd_pkg::ACT_HEADER:  state_next = ST_HDR;
                    rscd_pkg::ACT_STREAM:
                    begin
                        if (status.pending_nz)
                        begin
                            state_next = ST_LIT_RD;
                        end
                        else if (status.literal_flag)
                        begin
                            cmd.set_pending = 1'b1;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            cmd.run_load = 1'b1;
                            state_next   = ST_RUN;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_P_START:
            begin
                if (status.slot_ok)
                begin
                    cmd.pal_start = 1'b1;
                    state_next    = ST_P_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_P_READ:
            begin
                if (status.idx_at_count)
                begin
                    state_next = ST_P_ADD;
                end
                else
                begin
                    cmd.pal_rd = 1'b1;
                    state_next = ST_P_CMP;
                end
            end
            ST_P_CMP:
            begin
                if (status.match)
                begin
                    if (status.out_free)
                    begin
                        cmd.pal_found = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.pal_next = 1'b1;
                    state_next   = ST_P_READ;
                end
            end
            ST_P_ADD:
            begin
                if (status.out_free)
                begin
                    cmd.pal_add = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_HDR:
            begin
                cmd.hdr_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_LIT_RD:
            begin
                cmd.lit_rd = 1'b1;
                state_next = ST_LIT_OUT;
            end
            ST_LIT_OUT:
            begin
                if (!status.hit || status.out_free)
                begin
                    cmd.lit_emit = 1'b1;
                    cmd.advance  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (status.run_nz)
                begin
                    cmd.advance = 1'b1;
                    cmd.run_dec = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/rscd_dp.sv
// ---------------------------------------------------------------------------
// rscd_dp: decoder datapath
// Config registers, palette color and slot memories, column-major position,
// literal/run counters and the output register.
// ---------------------------------------------------------------------------
module rscd_dp
#(
    parameter int PALETTE_SIZE = rscd_pkg::PALETTE_SIZE_DEF,
    parameter int COORD_BITS   = rscd_pkg::COORD_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [rscd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [rscd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  rscd_pkg::item_t                        item,
    input  rscd_pkg::ctrl_cmd_t                    cmd,
    output rscd_pkg::dp_status_t                   status,
    input  logic                                   result_stall,
    output logic                                   result_valid,
    output rscd_pkg::result_t                      result
);

    localparam int AW     = $clog2(PALETTE_SIZE);
    localparam int CW     = $clog2(PALETTE_SIZE + 1);
    localparam int PW     = rscd_pkg::PROD_W;
    localparam int CMPW   = (COORD_BITS > PW) ? COORD_BITS : PW;
    localparam int ZW     = rscd_pkg::ZOOM_W;
    localparam int SW     = rscd_pkg::SRC_W;
    localparam int KW     = rscd_pkg::CODE_W;
    localparam int RW     = rscd_pkg::RUN_W;

    localparam logic [CW-1:0] FULL_COUNT = CW'(PALETTE_SIZE);
    localparam logic [AW-1:0] LAST_IDX   = AW'(PALETTE_SIZE - 1);
    localparam logic [KW-1:0] PAL_LIMIT  = KW'(PALETTE_SIZE);

    logic [ZW-1:0]  zoom_reg;
    logic [SW-1:0]  width_reg;
    logic [SW-1:0]  height_reg;
    rscd_pkg::item_t item_reg;
    logic [SW-1:0]  frame_top_reg;
    logic [SW-1:0]  frame_bottom_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] tz_reg;
    logic [PW-1:0]  bz_reg;
    logic [PW-1:0]  wz_reg;
    logic [PW-1:0]  hz_reg;
    logic [RW-1:0]  pending_reg;
    logic [RW-1:0]  run_reg;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  count_reg;
    logic           hit_reg;
    logic [rscd_pkg::COLOR_W-1:0] color_rdata_reg;
    logic [AW-1:0]  map_rdata_reg;
    logic           out_valid_reg;
    rscd_pkg::result_t out_reg;

    logic [rscd_pkg::COLOR_W-1:0] color_mem [PALETTE_SIZE];
    logic [AW-1:0]                map_mem   [PALETTE_SIZE];

    logic [PW-1:0]  left_prod;
    logic [PW-1:0]  top_prod;
    logic [COORD_BITS-1:0] zoom_c;
    logic [COORD_BITS-1:0] row_step;
    logic           wrap;
    logic [COORD_BITS-1:0] row_next;
    logic [COORD_BITS-1:0] col_next;
    logic           full;
    logic [AW-1:0]  pal_code;
    logic [CW-1:0]  count_next;
    logic           byte_ok;
    logic           emit;
    rscd_pkg::result_t res;

    assign zoom_c    = COORD_BITS'(zoom_reg);
    assign left_prod = {{ZW{1'b0}}, item_reg.left_column} * {{SW{1'b0}}, zoom_reg};
    assign top_prod  = {{ZW{1'b0}}, item_reg.top_row} * {{SW{1'b0}}, zoom_reg};

    assign row_step = row_reg + zoom_c;
    assign wrap     = CMPW'(row_step) >= CMPW'(bz_reg);
    assign row_next = wrap ? tz_reg : row_step;
    assign col_next = wrap ? (col_reg + zoom_c) : col_reg;

    assign full       = (count_reg == FULL_COUNT);
    assign pal_code   = (cmd.pal_add && full) ? LAST_IDX : idx_reg[AW-1:0];
    assign count_next = (cmd.pal_add && !full) ? (count_reg + CW'(1)) : count_reg;
    assign byte_ok    = {1'b0, item_reg.stream_byte} < PAL_LIMIT;
    assign emit       = cmd.pal_found || cmd.pal_add || (cmd.lit_emit && hit_reg);

    always_comb
    begin
        res = '0;
        if (cmd.lit_emit)
        begin
            res.kind       = rscd_pkg::KIND_PIXEL;
            res.pixel_x    = rscd_pkg::OUT_COORD_W'(col_reg);
            res.pixel_y    = rscd_pkg::OUT_COORD_W'(row_reg);
            res.color_code = byte_ok ? (KW'(map_rdata_reg) + KW'(1)) : '0;
        end
        else
        begin
            res.kind           = rscd_pkg::KIND_PALETTE;
            res.color_code     = KW'(pal_code) + KW'(1);
            res.is_new_color   = cmd.pal_add && !full;
            res.distinct_count = KW'(count_next);
        end
    end

    assign status.action       = item_reg.action;
    assign status.slot_ok      = {1'b0, item_reg.palette_slot} < PAL_LIMIT;
    assign status.idx_at_count = (idx_reg == count_reg);
    assign status.match        = (color_rdata_reg == item_reg.palette_color);
    assign status.pending_nz   = (pending_reg != '0);
    assign status.literal_flag = item_reg.stream_byte[SW-1];
    assign status.run_nz       = (run_reg != '0);
    assign status.hit          = hit_reg;
    assign status.out_free     = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg         <= rscd_pkg::ZOOM_RESET;
            width_reg        <= '0;
            height_reg       <= '0;
            frame_top_reg    <= '0;
            frame_bottom_reg <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            tz_reg           <= '0;
            bz_reg           <= '0;
            wz_reg           <= '0;
            hz_reg           <= '0;
            pending_reg      <= '0;
            run_reg          <= '0;
            idx_reg          <= '0;
            count_reg        <= '0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rscd_pkg::CFG_ZOOM:   zoom_reg   <= cfg_data[ZW-1:0];
                    rscd_pkg::CFG_WIDTH:  width_reg  <= cfg_data[SW-1:0];
                    rscd_pkg::CFG_HEIGHT: height_reg <= cfg_data[SW-1:0];
                    default: ;
                endcase
            end

            tz_reg <= COORD_BITS'({{ZW{1'b0}}, frame_top_reg} * {{SW{1'b0}}, zoom_reg});
            bz_reg <= {{ZW{1'b0}}, frame_bottom_reg} * {{SW{1'b0}}, zoom_reg};
            wz_reg <= {{ZW{1'b0}}, width_reg} * {{SW{1'b0}}, zoom_reg};
            hz_reg <= {{ZW{1'b0}}, height_reg} * {{SW{1'b0}}, zoom_reg};

            if (cmd.hdr_load)
            begin
                frame_top_reg    <= item_reg.top_row;
                frame_bottom_reg <= item_reg.bottom_row;
                col_reg          <= COORD_BITS'(left_prod);
                row_reg          <= COORD_BITS'(top_prod);
            end
            else if (cmd.advance)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (cmd.hdr_load)
            begin
                pending_reg <= '0;
            end
            else if (cmd.set_pending)
            begin
                pending_reg <= item_reg.stream_byte[RW-1:0];
            end
            else if (cmd.lit_rd)
            begin
                pending_reg <= pending_reg - RW'(1);
            end

            if (cmd.run_load)
            begin
                run_reg <= item_reg.stream_byte[RW-1:0];
            end
            else if (cmd.run_dec)
            begin
                run_reg <= run_reg - RW'(1);
            end

            if (cmd.pal_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.pal_next)
            begin
                idx_reg <= idx_reg + CW'(1);
            end

            if (cmd.pal_start && (item_reg.palette_slot == '0))
            begin
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end

            if (cmd.lit_rd)
            begin
                hit_reg <= (CMPW'(col_reg) < CMPW'(wz_reg)) &&
                           (CMPW'(row_reg) < CMPW'(hz_reg));
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (emit)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pal_add && !full)
        begin
            color_mem[idx_reg[AW-1:0]] <= item_reg.palette_color;
        end
        if (cmd.pal_rd)
        begin
            color_rdata_reg <= color_mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pal_found || cmd.pal_add)
        begin
            map_mem[item_reg.palette_slot[AW-1:0]] <= pal_code;
        end
        if (cmd.lit_rd)
        begin
            map_rdata_reg <= map_mem[item_reg.stream_byte[AW-1:0]];
        end
    end

endmodule

FILE: design/rscd_checker.sv
// ---------------------------------------------------------------------------
// rscd_checker: port-level checks for the decoder
// Output hold, busy after intake, results only from a beat in work, and consistency of result fields.
// ---------------------------------------------------------------------------
module rscd_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input rscd_pkg::result_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
    else $error("input taken while previous beat still in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
    else $error("result beat appeared with no beat in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == rscd_pkg::KIND_PALETTE) |->
            (result.color_code != '0) && (result.color_code <= result.distinct_count) &&
            (!result.is_new_color || (result.color_code == result.distinct_count)))
    else $error("palette result code inconsistent with distinct count");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == rscd_pkg::KIND_PIXEL) |->
            !result.is_new_color && (result.distinct_count == '0))
    else $error("pixel write carries palette fields");

endmodule

bind rle_sprite_column_decoder_core rscd_checker u_rscd_checker (.*);
